// ===== hw/rtl/rsbk_pkg.sv =====
//------------------------------------------------------------------------------
// rsbk_pkg
// Shared types and constants of the record sort core: record layout, counter
// widths, controller states and the command/status bundles.
//------------------------------------------------------------------------------
package rsbk_pkg;

	// Capacity of the record store
	localparam int MAX_RECORDS = 64;
	// Counter width: holds 0 .. MAX_RECORDS
	localparam int CNT_W = $clog2(MAX_RECORDS + 1);

	localparam int ID_W    = 16;
	localparam int PRICE_W = 32;
	localparam int REC_W   = ID_W + PRICE_W;

	// One record; id sits in the low bits, as on the stream data bus
	typedef struct packed {
		logic signed [PRICE_W-1:0] price;
		logic [ID_W-1:0]           id;
	} rec_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SORT,
		ST_EMIT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;       // input beat accepted
		logic sort_init;  // last record accepted, clear round counter
		logic sort_step;  // one odd/even compare-exchange round
		logic emit_step;  // move head cell into output register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic sort_done;  // current round is the final one
		logic emit_last;  // one record left in the cells
		logic out_free;   // output register can take a beat
	} status_t;

endpackage

// ===== hw/rtl/rsbk_ctrl.sv =====
//------------------------------------------------------------------------------
// rsbk_ctrl
// Sequencer of the record sort core: load records, run the sort rounds,
// drain the sorted cells to the output register.
//------------------------------------------------------------------------------
module rsbk_ctrl
	import rsbk_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_last,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_valid && in_last) begin
					state_d = ST_SORT;
				end
			end
			ST_SORT: begin
				if (status.sort_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free && status.emit_last) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// Outputs
	always_comb begin
		in_ready      = 1'b0;
		cmd           = '0;
		case (state_q)
			ST_LOAD: begin
				in_ready      = 1'b1;
				cmd.load      = in_valid;
				cmd.sort_init = in_valid && in_last;
			end
			ST_SORT: begin
				cmd.sort_step = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit_step = status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ===== hw/rtl/rsbk_datapath.sv =====
//------------------------------------------------------------------------------
// rsbk_datapath
// Row of record cells with neighbor compare-exchange (odd/even transposition),
// set counters, direction register and the output register.
//------------------------------------------------------------------------------
module rsbk_datapath
	import rsbk_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic             cfg_wr_data,
	input  rec_t             in_rec,
	input  cmd_t             cmd,
	output status_t          status,
	output logic             out_valid,
	input  logic             out_ready,
	output rec_t             out_rec,
	output logic             out_last,
	output logic             out_ovf
);

	rec_t             cell_q [MAX_RECORDS];
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] round_q;
	logic             dropped_q;
	logic             asc_q;
	logic             full;

	// Per-cell neighbor wiring
	logic             swap    [MAX_RECORDS-1];
	logic             swap_hi [MAX_RECORDS];
	logic             swap_lo [MAX_RECORDS];
	rec_t             rec_hi  [MAX_RECORDS];
	rec_t             rec_lo  [MAX_RECORDS];
	logic             load_hit [MAX_RECORDS];

	assign full = (count_q == CNT_W'(MAX_RECORDS));

	// Compare-exchange of pair (i, i+1): active on pairs of the current phase
	// inside the filled region; strict compare keeps equal prices in order
	for (genvar i = 0; i < MAX_RECORDS - 1; i++) begin : g_pair
		logic pair_act;
		logic misorder;
		assign pair_act = (round_q[0] == 1'(i % 2)) && (CNT_W'(i + 1) < count_q);
		assign misorder = asc_q ? (cell_q[i].price > cell_q[i+1].price)
		                        : (cell_q[i].price < cell_q[i+1].price);
		assign swap[i]  = pair_act && misorder;
	end

	for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
		assign load_hit[i] = cmd.load && !full && (count_q == CNT_W'(i));
		if (i == MAX_RECORDS - 1) begin : g_top
			assign swap_hi[i] = 1'b0;
			assign rec_hi[i]  = cell_q[i];
		end else begin : g_mid_hi
			assign swap_hi[i] = swap[i];
			assign rec_hi[i]  = cell_q[i+1];
		end
		if (i == 0) begin : g_bot
			assign swap_lo[i] = 1'b0;
			assign rec_lo[i]  = cell_q[i];
		end else begin : g_mid_lo
			assign swap_lo[i] = swap[i-1];
			assign rec_lo[i]  = cell_q[i-1];
		end
	end

	// Record cells: load at fill position, exchange, or shift toward head
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RECORDS; i++) begin
			if (load_hit[i]) begin
				cell_q[i] <= in_rec;
			end else if (cmd.sort_step) begin
				if (swap_hi[i]) begin
					cell_q[i] <= rec_hi[i];
				end else if (swap_lo[i]) begin
					cell_q[i] <= rec_lo[i];
				end
			end else if (cmd.emit_step) begin
				cell_q[i] <= rec_hi[i];
			end
		end
	end

	// Set counters and direction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			round_q   <= '0;
			dropped_q <= 1'b0;
			asc_q     <= 1'b1;
		end else begin
			if (cfg_wr_en) begin
				asc_q <= cfg_wr_data;
			end
			if (cmd.load) begin
				if (full) begin
					dropped_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (cmd.sort_init) begin
				round_q <= '0;
			end else if (cmd.sort_step) begin
				round_q <= round_q + CNT_W'(1);
			end
			if (cmd.emit_step) begin
				count_q <= count_q - CNT_W'(1);
				if (status.emit_last) begin
					dropped_q <= 1'b0;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit_step) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_step) begin
			out_rec  <= cell_q[0];
			out_last <= status.emit_last;
			out_ovf  <= dropped_q;
		end
	end

	// Status back to the controller
	always_comb begin
		status.sort_done = ((round_q + CNT_W'(1)) >= count_q);
		status.emit_last = (count_q == CNT_W'(1));
		status.out_free  = !out_valid || out_ready;
	end

endmodule

// ===== hw/rtl/record_sort_by_key_core.sv =====
//------------------------------------------------------------------------------
// record_sort_by_key_core
// Collects records until a beat marked last, then emits them stably sorted by
// price, rising or falling as the ascending register selects.
//------------------------------------------------------------------------------
// Records arrive one per cycle and fill a row of up to MAX_RECORDS (64) cells;
// records beyond that are dropped and every result of the set flags overflow.
// A beat with tlast closes the set: the row then runs N odd/even
// compare-exchange rounds, one per cycle (N = records held), and drains its
// head cell into the output register one record per cycle while the sink
// accepts. No input is taken during sort and drain. Records of equal price leave
// in arrival order in both directions. The ascending register (reset 1) is
// written with cfg_wr_en/cfg_wr_data; the user must write it only while no set
// is pending, as the core itself does not enforce this.
//------------------------------------------------------------------------------
module record_sort_by_key_core
	import rsbk_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// Configuration: ascending register
	input  logic              cfg_wr_en,
	input  logic              cfg_wr_data,
	// Input stream
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [REC_W-1:0]  s_axis_tdata,   // [15:0] record_id, [47:16] price
	input  logic              s_axis_tlast,   // last_in
	// Output stream
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [REC_W-1:0]  m_axis_tdata,   // [15:0] sorted_id, [47:16] sorted_price
	output logic              m_axis_tlast,   // last_out
	output logic              m_axis_tuser    // [0] overflow
);

	cmd_t    cmd;
	status_t status;
	rec_t    out_rec;

	rsbk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	rsbk_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_rec      (rec_t'(s_axis_tdata)),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_rec     (out_rec),
		.out_last    (m_axis_tlast),
		.out_ovf     (m_axis_tuser)
	);

	assign m_axis_tdata = out_rec;

endmodule

// ===== bench/record_sort_by_key_core_tb.sv =====
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// record_sort_by_key_core_tb
// Self-checking bench for the record sort core: record sets go in on the input
// stream, and every sorted beat that comes out is compared with a predicted
// stable sort of the same set. Covers field extremes, equal keys, both sort
// orders, store overflow, output back-pressure and random idling on both sides.
//------------------------------------------------------------------------------
module record_sort_by_key_core_tb
	import rsbk_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 2000;  // cycles without any accepted beat
	localparam int HOLD_CYCLES    = 400;   // long sink hold-off
	localparam int SETTLE_CYCLES  = 12;    // quiet time after the last result

	// One expected output beat
	typedef struct {
		rec_t rec;
		logic last;
		logic ovf;
	} sorted_beat_t;

	logic             clk             = 1'b0;
	logic             arst_n          = 1'b0;
	logic             cfg_wr_en       = 1'b0;
	logic             cfg_wr_data     = 1'b0;
	logic             s_axis_tvalid   = 1'b0;
	logic             s_axis_tready;
	logic [REC_W-1:0] s_axis_tdata    = '0;  // [15:0] record_id, [47:16] price
	logic             s_axis_tlast    = 1'b0; // last_in
	logic             m_axis_tvalid;
	logic             m_axis_tready   = 1'b0;
	logic [REC_W-1:0] m_axis_tdata;          // [15:0] sorted_id, [47:16] sorted_price
	logic             m_axis_tlast;          // last_out
	logic             m_axis_tuser;          // [0] overflow

	// Predictor state
	rec_t         held_recs[$];
	logic         held_dropped = 1'b0;
	logic         sort_rising  = 1'b1;
	sorted_beat_t sorted_due[$];

	int   fail_count = 0;
	logic idle_en    = 1'b1;
	int   hold_req   = 0;
	int   hold_ack   = 0;
	int   sink_wait  = 0;
	int   quiet_cycles = 0;

	record_sort_by_key_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	// True when record a leaves strictly ahead of record b in the current order
	function automatic logic key_ahead(rec_t a, rec_t b);
		if (sort_rising)
			return $signed(a.price) < $signed(b.price);
		return $signed(a.price) > $signed(b.price);
	endfunction

	// Store one accepted record; on a closing record, queue the sorted set
	task automatic predict_record(rec_t r, logic last);
		rec_t         ordered[$];
		sorted_beat_t b;
		int           pos;
		if (held_recs.size() < MAX_RECORDS)
			held_recs.push_back(r);
		else
			held_dropped = 1'b1;
		if (last) begin
			// stable insertion: equal keys stay behind earlier arrivals
			foreach (held_recs[i]) begin
				pos = 0;
				while (pos < ordered.size() && !key_ahead(held_recs[i], ordered[pos]))
					pos++;
				ordered.insert(pos, held_recs[i]);
			end
			foreach (ordered[i]) begin
				b.rec  = ordered[i];
				b.last = (i == ordered.size() - 1);
				b.ovf  = held_dropped;
				sorted_due.push_back(b);
			end
			held_recs.delete();
			held_dropped = 1'b0;
		end
	endtask

	// Offer one record and wait for the beat; tvalid stays up if no gap follows
	task automatic send_record(logic [ID_W-1:0] id, logic [PRICE_W-1:0] price, logic last);
		rec_t r;
		int   gap;
		r.id          = id;
		r.price       = price;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= r;
		s_axis_tlast  <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		predict_record(r, last);
		gap = (idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop tvalid, then wait for every predicted result plus a quiet stretch
	task automatic wait_results_done();
		s_axis_tvalid <= 1'b0;
		while (sorted_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_order(logic rising);
		wait_results_done();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= rising;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		sort_rising = rising;
	endtask

	function automatic logic [PRICE_W-1:0] rand_price();
		// a third of the keys come from a narrow band to force ties
		if ($urandom_range(0, 2) == 0)
			return $urandom_range(0, 6) - 3;
		return $urandom;
	endfunction

	task automatic send_random_set(int len);
		for (int k = 0; k < len; k++)
			send_record(ID_W'($urandom_range(0, 65535)), rand_price(), k == len - 1);
	endtask

	// Random sets until the record budget is used up; mostly short sets
	task automatic send_random_sets(int budget);
		int len;
		while (budget > 0) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			if (len > budget)
				len = budget;
			send_random_set(len);
			budget -= len;
		end
	endtask

	// Extremes, equal keys and a single-record set, in both orders
	task automatic test_directed();
		for (int pass = 0; pass < 2; pass++) begin
			if (pass == 1)
				write_order(1'b0);
			send_record(16'h0000, 32'h8000_0000, 1'b0);
			send_record(16'hFFFF, 32'h7FFF_FFFF, 1'b0);
			send_record(16'h1234, 32'h0000_0000, 1'b0);
			send_record(16'h0001, 32'hFFFF_FFFF, 1'b0);
			send_record(16'h0002, 32'h0000_0001, 1'b0);
			send_record(16'h0003, 32'h0000_0000, 1'b0);
			send_record(16'h0004, 32'hFFFF_FFFF, 1'b0);
			send_record(16'h5555, 32'h7FFF_FFFF, 1'b0);
			send_record(16'hAAAA, 32'h8000_0000, 1'b1);
			send_record(16'h0F0F, 32'hA5A5_5A5A, 1'b1);
		end
		write_order(1'b1);
	endtask

	// Exactly full store, then a set whose tail and closing record are dropped
	task automatic test_overflow();
		send_random_set(MAX_RECORDS);
		wait_results_done();
		send_random_set(MAX_RECORDS + 2);
		wait_results_done();
	endtask

	// Sink holds off while sets keep coming, so the core must stall its input
	task automatic test_backpressure();
		hold_req++;
		repeat (3) send_random_set(10);
		wait_results_done();
	endtask

	task automatic test_random();
		send_random_sets(70);
		write_order(1'b0);
		send_random_sets(70);
		write_order(1'b1);
		send_random_sets(40);
		// closing stretch with no idling on either side
		wait_results_done();
		idle_en = 1'b0;
		send_random_sets(40);
		write_order(1'b0);
		send_random_sets(30);
	endtask

	// Compare one output beat with the oldest prediction
	task automatic check_beat();
		sorted_beat_t b;
		rec_t         got;
		got = m_axis_tdata;
		if (sorted_due.size() == 0) begin
			fail_count++;
			$display("%0t unexpected beat: expected none, got id %h price %h", $time,
				got.id, got.price);
		end else begin
			b = sorted_due.pop_front();
			if (got.id !== b.rec.id) begin
				fail_count++;
				$display("%0t sorted_id: expected %h, got %h", $time, b.rec.id, got.id);
			end
			if (got.price !== b.rec.price) begin
				fail_count++;
				$display("%0t sorted_price: expected %h, got %h", $time, b.rec.price,
					got.price);
			end
			if (m_axis_tlast !== b.last) begin
				fail_count++;
				$display("%0t last_out: expected %b, got %b", $time, b.last, m_axis_tlast);
			end
			if (m_axis_tuser !== b.ovf) begin
				fail_count++;
				$display("%0t overflow: expected %b, got %b", $time, b.ovf, m_axis_tuser);
			end
		end
	endtask

	// Output side: check accepted beats, then pick next tready
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				check_beat();
			if (hold_ack != hold_req) begin
				hold_ack  = hold_req;
				sink_wait = HOLD_CYCLES;
			end
			if (sink_wait > 0) begin
				sink_wait--;
				m_axis_tready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				sink_wait = $urandom_range(1, 13) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog: too long without any beat on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_overflow();
		test_backpressure();
		test_random();
		wait_results_done();
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== record_sort_by_key_core.f =====
hw/rtl/rsbk_pkg.sv
hw/rtl/rsbk_ctrl.sv
hw/rtl/rsbk_datapath.sv
hw/rtl/record_sort_by_key_core.sv
bench/record_sort_by_key_core_tb.sv
